>>> hw/rtl/rgip_pkg.sv
// shared types, codes and defaults for the relay group interlock pulser
package rgip_pkg;

    localparam int NUM_RELAYS_DEF    = 4;
    localparam int GROUP_ID_BITS_DEF = 4;

    localparam int MAP_W   = 16;
    localparam int WIDTH_W = 16;
    localparam int IDX_W   = 8;
    localparam int REQ_W   = 3;
    localparam int STATE_W = 4;
    localparam int STAT_W  = 2;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [REQ_W-1:0] REQ_ON     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_OFF    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TOGGLE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_PULSE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STAT_W-1:0] ST_BLOCKED   = 2'd2;
    localparam logic [STAT_W-1:0] ST_PULSING   = 2'd3;

    localparam logic [1:0] REG_GROUPS_EN   = 2'd0;
    localparam logic [1:0] REG_GROUP_MAP   = 2'd1;
    localparam logic [1:0] REG_PULSE_WIDTH = 2'd2;

    localparam logic [WIDTH_W-1:0] PULSE_WIDTH_RST = 16'd1000;

    typedef struct packed {
        logic               groups_en;
        logic [MAP_W-1:0]   group_map;
        logic [WIDTH_W-1:0] pulse_width;
    } t_cfg;

endpackage

>>> hw/rtl/rgip_cfg.sv
// apb register file holding the interlock and pulse settings
module rgip_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rgip_pkg::ADDR_W-1:0] paddr,
    input  logic [rgip_pkg::DATA_W-1:0] pwdata,
    output logic [rgip_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output rgip_pkg::t_cfg              o_cfg
);

    logic                           r_groups_en;
    logic [rgip_pkg::MAP_W-1:0]     r_group_map;
    logic [rgip_pkg::WIDTH_W-1:0]   r_pulse_width;
    logic                           w_wr;
    logic [1:0]                     w_reg;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_groups_en   <= 1'b0;
            r_group_map   <= '0;
            r_pulse_width <= rgip_pkg::PULSE_WIDTH_RST;
        end else if (w_wr) begin
            case (w_reg)
                rgip_pkg::REG_GROUPS_EN:   r_groups_en   <= pwdata[0];
                rgip_pkg::REG_GROUP_MAP:   r_group_map   <= pwdata[rgip_pkg::MAP_W-1:0];
                rgip_pkg::REG_PULSE_WIDTH: r_pulse_width <= pwdata[rgip_pkg::WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            rgip_pkg::REG_GROUPS_EN:   prdata = {31'd0, r_groups_en};
            rgip_pkg::REG_GROUP_MAP:   prdata = {16'd0, r_group_map};
            rgip_pkg::REG_PULSE_WIDTH: prdata = {16'd0, r_pulse_width};
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg.groups_en   = r_groups_en;
    assign o_cfg.group_map   = r_group_map;
    assign o_cfg.pulse_width = r_pulse_width;

endmodule

>>> hw/rtl/rgip_core.sv
// relay state, pulse counters and the single-pass command logic
module rgip_core #(
    parameter int NUM_RELAYS    = rgip_pkg::NUM_RELAYS_DEF,
    parameter int GROUP_ID_BITS = rgip_pkg::GROUP_ID_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [rgip_pkg::REQ_W-1:0]   i_req,
    input  logic [rgip_pkg::IDX_W-1:0]   i_idx,
    input  rgip_pkg::t_cfg               i_cfg,
    output logic [rgip_pkg::STATE_W-1:0] o_relay_states,
    output logic [rgip_pkg::STAT_W-1:0]  o_status
);

    logic [NUM_RELAYS-1:0]          r_on;
    logic [NUM_RELAYS-1:0]          r_pul;
    logic [rgip_pkg::WIDTH_W-1:0]   r_el [NUM_RELAYS];
    logic [NUM_RELAYS-1:0]          n_on;
    logic [NUM_RELAYS-1:0]          n_pul;
    logic [rgip_pkg::WIDTH_W-1:0]   n_el [NUM_RELAYS];

    logic [GROUP_ID_BITS-1:0]       w_grp [NUM_RELAYS];
    logic [NUM_RELAYS-1:0]          w_sel;
    logic [NUM_RELAYS-1:0]          w_same;
    logic [GROUP_ID_BITS-1:0]       w_tgt_grp;
    logic [rgip_pkg::WIDTH_W-1:0]   w_tick_el [NUM_RELAYS];
    logic [NUM_RELAYS-1:0]          w_tick_done;
    logic                           w_idx_ok;
    logic                           w_busy;
    logic                           w_tgt_on;
    logic                           w_tgt_pul;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_RELAYS; gi++) begin : g_relay
            localparam int SH = gi * GROUP_ID_BITS;
            // ids lying above the map read as group zero
            if (SH >= rgip_pkg::MAP_W) begin : g_nomap
                assign w_grp[gi] = '0;
            end else begin : g_map
                assign w_grp[gi] = GROUP_ID_BITS'(i_cfg.group_map >> SH);
            end
            assign w_sel[gi]  = (i_idx == rgip_pkg::IDX_W'(gi));
            assign w_same[gi] = r_on[gi] && (w_grp[gi] == w_tgt_grp);
            // saturating count, pulse ends once it reaches the width
            assign w_tick_el[gi] = (r_el[gi] < i_cfg.pulse_width) ?
                                   r_el[gi] + 16'd1 : r_el[gi];
            assign w_tick_done[gi] = (w_tick_el[gi] >= i_cfg.pulse_width);
        end

        for (gi = 0; gi < rgip_pkg::STATE_W; gi++) begin : g_out
            if (gi < NUM_RELAYS) begin : g_bit
                assign o_relay_states[gi] = n_on[gi];
            end else begin : g_zero
                assign o_relay_states[gi] = 1'b0;
            end
        end
    endgenerate

    always_comb begin
        w_tgt_grp = '0;
        for (int i = 0; i < NUM_RELAYS; i++) begin
            if (w_sel[i]) w_tgt_grp = w_grp[i];
        end
    end

    assign w_idx_ok  = |w_sel;
    assign w_busy    = i_cfg.groups_en && (|w_same);
    assign w_tgt_on  = |(w_sel & r_on);
    assign w_tgt_pul = |(w_sel & r_pul);

    always_comb begin
        n_on     = r_on;
        n_pul    = r_pul;
        n_el     = r_el;
        o_status = rgip_pkg::ST_OK;
        case (i_req)
            rgip_pkg::REQ_TICK: begin
                for (int i = 0; i < NUM_RELAYS; i++) begin
                    if (r_pul[i]) begin
                        n_el[i] = w_tick_el[i];
                        if (w_tick_done[i]) begin
                            n_on[i]  = 1'b0;
                            n_pul[i] = 1'b0;
                        end
                    end
                end
            end
            rgip_pkg::REQ_ON: begin
                if (!w_idx_ok) begin
                    o_status = rgip_pkg::ST_BAD_INDEX;
                end else if (w_busy) begin
                    o_status = rgip_pkg::ST_BLOCKED;
                end else begin
                    n_on = r_on | w_sel;
                end
            end
            rgip_pkg::REQ_OFF: begin
                if (!w_idx_ok) begin
                    o_status = rgip_pkg::ST_BAD_INDEX;
                end else begin
                    n_on = r_on & ~w_sel;
                end
            end
            rgip_pkg::REQ_TOGGLE: begin
                if (!w_idx_ok) begin
                    o_status = rgip_pkg::ST_BAD_INDEX;
                end else if (w_tgt_on) begin
                    n_on = r_on & ~w_sel;
                end else if (w_busy) begin
                    o_status = rgip_pkg::ST_BLOCKED;
                end else begin
                    n_on = r_on | w_sel;
                end
            end
            rgip_pkg::REQ_PULSE: begin
                if (!w_idx_ok) begin
                    o_status = rgip_pkg::ST_BAD_INDEX;
                end else if (w_tgt_pul) begin
                    o_status = rgip_pkg::ST_PULSING;
                end else begin
                    // pulse stays armed even when the switch-on is blocked
                    n_pul = r_pul | w_sel;
                    for (int i = 0; i < NUM_RELAYS; i++) begin
                        if (w_sel[i]) n_el[i] = '0;
                    end
                    if (w_busy) begin
                        o_status = rgip_pkg::ST_BLOCKED;
                    end else begin
                        n_on = r_on | w_sel;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on  <= '0;
            r_pul <= '0;
            for (int i = 0; i < NUM_RELAYS; i++) r_el[i] <= '0;
        end else if (i_en) begin
            r_on  <= n_on;
            r_pul <= n_pul;
            for (int i = 0; i < NUM_RELAYS; i++) r_el[i] <= n_el[i];
        end
    end

endmodule

>>> hw/rtl/relay_group_interlock_pulser_core.sv
// relay bank with group interlock and timed pulses: top level
// an accepted item is held in the input register, then passes through the command logic
// into the result register, from which its result is offered
// throughput: one item per cycle while m_axis_tready is high
// reset (i_rst_n low, synchronous): relays off, no pulse armed, counters zero,
// registers back to groups off, empty group map, pulse width 1000
module relay_group_interlock_pulser_core #(
    parameter int NUM_RELAYS    = rgip_pkg::NUM_RELAYS_DEF,
    parameter int GROUP_ID_BITS = rgip_pkg::GROUP_ID_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] relay_index
    input  logic [2:0]                  s_axis_tuser,   // [2:0] req_type
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // [3:0] relay_states, [5:4] status
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rgip_pkg::ADDR_W-1:0] paddr,
    input  logic [rgip_pkg::DATA_W-1:0] pwdata,
    output logic [rgip_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    rgip_pkg::t_cfg                 w_cfg;
    logic                           r_in_valid;
    logic [rgip_pkg::REQ_W-1:0]     r_req;
    logic [rgip_pkg::IDX_W-1:0]     r_idx;
    logic                           r_out_valid;
    logic [rgip_pkg::STATE_W-1:0]   r_states;
    logic [rgip_pkg::STAT_W-1:0]    r_status;
    logic [rgip_pkg::STATE_W-1:0]   w_states;
    logic [rgip_pkg::STAT_W-1:0]    w_status;
    logic                           w_exec;
    logic                           w_take;

    rgip_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // item in the input register executes when the result register is empty or is being read
    assign w_exec        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_exec;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    rgip_core #(
        .NUM_RELAYS    (NUM_RELAYS),
        .GROUP_ID_BITS (GROUP_ID_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_exec),
        .i_req          (r_req),
        .i_idx          (r_idx),
        .i_cfg          (w_cfg),
        .o_relay_states (w_states),
        .o_status       (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_exec) begin
                r_in_valid <= 1'b0;
            end
            if (w_exec) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req <= s_axis_tuser;
            r_idx <= s_axis_tdata;
        end
        if (w_exec) begin
            r_states <= w_states;
            r_status <= w_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_status, r_states};

endmodule
